@@ hdl/assert_macros.svh @@
// Assertion helpers used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is high.
`define ICMPP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ICMPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/icmpp_pkg.sv @@
// ----------------------------------------------------------------------------
// ICMP parse package
// Shared constants, result status codes, control struct and the
// ones-complement add used by the checksum datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package icmpp_pkg;

   localparam int MAX_MESSAGE_BYTES_DEFAULT = 4096;
   localparam int HEADER_BYTES              = 8;
   localparam int WORD_BITS                 = 16;
   localparam int PAYLOAD_CAP               = 4095;
   localparam int PAYLOAD_BITS              = 12;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_SHORT   = 2'd1,
      ST_BAD_SUM = 2'd2,
      ST_LONG    = 2'd3
   } status_type;

   // Per-beat control from the parser to the checksum unit.
   typedef struct packed {
      logic advance;    // a beat moves through the parse stage
      logic add_pair;   // odd position except 3: add {high byte, this byte}
      logic load_high;  // even position except 2: hold this byte as high half
      logic pad_last;   // final even byte: add {this byte, zero}
      logic restart;    // last beat: clear for the next message
   } csum_ctl_type;

   function automatic logic [WORD_BITS-1:0] oc_add(input logic [WORD_BITS-1:0] a,
                                                   input logic [WORD_BITS-1:0] b);
      logic [WORD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_BITS-1:0] + {{(WORD_BITS-1){1'b0}}, s[WORD_BITS]};
   endfunction

endpackage

`default_nettype wire

@@ hdl/icmp_message_parse_checksum.sv @@
// ----------------------------------------------------------------------------
// ICMP message parser with checksum check
// Byte-stream ICMP header capture, payload count and Internet checksum.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one message byte per beat in wire order; req_last_byte marks the
//            final byte. A beat moves when req_valid is high and req_stall low.
//   rsp_*  : one result beat per message, on its last byte: type, code,
//            rest of header, payload length and status (ok, too short,
//            checksum mismatch, too long). Taken when rsp_valid && !rsp_stall.
//   Throughput: one byte per cycle unless stalled, including back-to-back
//            one-byte messages, set by the single count/header/sum parse stage.
//   Path:    a result's last byte is taken into the input register, then parsed
//            into the result register, whose outputs drive rsp_*.
//   Stall:  while rsp_stall holds a waiting result, non-last bytes keep
//            flowing; only a second last byte waits in the input register,
//            and req_stall rises until the result slot frees.
//   Reset:  synchronous, clears count, sum, header capture and both valid
//            flags; the first byte after reset starts a new message.
//   Bytes beyond MAX_MESSAGE_BYTES are dropped and the message reports
//   too long, with the payload length held at the bound minus eight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module icmp_message_parse_checksum #(
   parameter int MAX_MESSAGE_BYTES = icmpp_pkg::MAX_MESSAGE_BYTES_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [7:0]                           req_data_byte,
   input  wire logic                                 req_last_byte,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [7:0]                                rsp_msg_type,
   output logic [7:0]                                rsp_msg_code,
   output logic [31:0]                               rsp_rest_of_header,
   output logic [icmpp_pkg::PAYLOAD_BITS-1:0]        rsp_payload_length,
   output logic [1:0]                                rsp_status
);

   // Count holds 0..MAX_MESSAGE_BYTES; overflow is a separate flag.
   localparam int CW = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int LW = (CW > icmpp_pkg::PAYLOAD_BITS) ? CW : icmpp_pkg::PAYLOAD_BITS;
   localparam logic [CW-1:0] BOUND  = CW'(MAX_MESSAGE_BYTES);
   localparam logic [CW-1:0] HDR    = CW'(icmpp_pkg::HEADER_BYTES);
   localparam logic [CW-1:0] POS_2  = CW'(2);
   localparam logic [CW-1:0] POS_3  = CW'(3);
   localparam logic [CW-1:0] POS_4  = CW'(4);
   localparam logic [CW-1:0] POS_0  = CW'(0);
   localparam logic [CW-1:0] POS_1  = CW'(1);
   localparam logic [LW-1:0] HDR_L  = LW'(icmpp_pkg::HEADER_BYTES);
   localparam logic [LW-1:0] CAP_L  = LW'(icmpp_pkg::PAYLOAD_CAP);

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Parse state.
   logic [CW-1:0]  count_ff, count_in;
   logic           over_ff, over_in;
   logic [7:0]     type_ff, type_in, type_nx;
   logic [7:0]     code_ff, code_in, code_nx;
   logic [15:0]    recv_ff, recv_in, recv_nx;
   logic [31:0]    rest_ff, rest_in, rest_nx;

   // Result register.
   logic                                   out_valid_ff;
   logic [7:0]                             out_type_ff;
   logic [7:0]                             out_code_ff;
   logic [31:0]                            out_rest_ff;
   logic [icmpp_pkg::PAYLOAD_BITS-1:0]     out_plen_ff, out_plen_in;
   icmpp_pkg::status_type                  out_status_ff, out_status_in;

   logic                      advance;
   logic                      load_out;
   logic                      too_long;
   logic                      take;
   logic [CW-1:0]             count_after;
   logic [LW-1:0]             count_ext;
   logic [LW-1:0]             plen_wide;
   logic [15:0]               check_calc;
   icmpp_pkg::csum_ctl_type   csum_ctl;

   // Hold a last byte only when the result slot is full and stalled.
   assign advance   = in_valid_ff && !(in_last_ff && out_valid_ff && rsp_stall);
   assign load_out  = advance && in_last_ff;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // Position decode and header capture; the byte at the bound is dropped.
   always_comb begin
      too_long = over_ff || (count_ff == BOUND);
      take     = !too_long;

      type_nx = (take && count_ff == POS_0) ? in_byte_ff : type_ff;
      code_nx = (take && count_ff == POS_1) ? in_byte_ff : code_ff;
      recv_nx = recv_ff;
      if (take && count_ff == POS_2) begin
         recv_nx = {in_byte_ff, recv_ff[7:0]};
      end else if (take && count_ff == POS_3) begin
         recv_nx = {recv_ff[15:8], in_byte_ff};
      end
      rest_nx = (take && count_ff >= POS_4 && count_ff < HDR) ?
                {rest_ff[23:0], in_byte_ff} : rest_ff;

      csum_ctl.advance   = advance;
      csum_ctl.add_pair  = take && count_ff[0] && (count_ff != POS_3);
      csum_ctl.load_high = take && !count_ff[0] && (count_ff != POS_2);
      csum_ctl.pad_last  = in_last_ff && csum_ctl.load_high;
      csum_ctl.restart   = in_last_ff;

      count_in = count_ff;
      over_in  = over_ff;
      type_in  = type_ff;
      code_in  = code_ff;
      recv_in  = recv_ff;
      rest_in  = rest_ff;
      if (advance) begin
         if (in_last_ff) begin
            count_in = '0;
            over_in  = 1'b0;
            type_in  = '0;
            code_in  = '0;
            recv_in  = '0;
            rest_in  = '0;
         end else begin
            count_in = take ? count_ff + CW'(1) : count_ff;
            over_in  = too_long;
            type_in  = type_nx;
            code_in  = code_nx;
            recv_in  = recv_nx;
            rest_in  = rest_nx;
         end
      end
   end

   icmpp_csum u_csum (
      .clock      (clock),
      .reset      (reset),
      .ctl        (csum_ctl),
      .data_byte  (in_byte_ff),
      .check_calc (check_calc)
   );

   // Result: length past the header, capped, and the status by priority.
   always_comb begin
      count_after = too_long ? BOUND : count_ff + CW'(1);
      count_ext   = LW'(count_after);
      plen_wide   = (count_ext > HDR_L) ? count_ext - HDR_L : '0;
      out_plen_in = (plen_wide > CAP_L) ? icmpp_pkg::PAYLOAD_BITS'(CAP_L) :
                                          plen_wide[icmpp_pkg::PAYLOAD_BITS-1:0];
      if (too_long) begin
         out_status_in = icmpp_pkg::ST_LONG;
      end else if (count_after < HDR) begin
         out_status_in = icmpp_pkg::ST_SHORT;
      end else if (check_calc != recv_ff) begin
         out_status_in = icmpp_pkg::ST_BAD_SUM;
      end else begin
         out_status_in = icmpp_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         over_ff      <= 1'b0;
         type_ff      <= '0;
         code_ff      <= '0;
         recv_ff      <= '0;
         rest_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         over_ff  <= over_in;
         type_ff  <= type_in;
         code_ff  <= code_in;
         recv_ff  <= recv_in;
         rest_ff  <= rest_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_type_ff   <= type_nx;
         out_code_ff   <= code_nx;
         out_rest_ff   <= rest_nx;
         out_plen_ff   <= out_plen_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_msg_type       = out_type_ff;
   assign rsp_msg_code       = out_code_ff;
   assign rsp_rest_of_header = out_rest_ff;
   assign rsp_payload_length = out_plen_ff;
   assign rsp_status         = out_status_ff;

   `ICMPP_ASSERT(a_over_saturated, clock, reset, over_ff |-> (count_ff == BOUND), "overflow without saturated count")
   `ICMPP_ASSERT(a_last_restarts, clock, reset, (advance && in_last_ff) |=> (count_ff == POS_0 && !over_ff), "last byte did not restart the message")
   `ICMPP_ASSERT(a_short_no_payload, clock, reset, (out_valid_ff && out_status_ff == icmpp_pkg::ST_SHORT) |-> (out_plen_ff == '0), "short message with payload length")
   `ICMPP_ASSERT(a_reset_clears, clock, reset, $past(reset) |-> (!out_valid_ff && !in_valid_ff && count_ff == POS_0), "reset left state behind")

endmodule

`default_nettype wire

@@ hdl/icmpp_csum.sv @@
// ----------------------------------------------------------------------------
// ICMP checksum accumulator
// Keeps a folded 16-bit ones-complement sum of big-endian words and gives
// the complement of the sum that includes the current beat.
// ----------------------------------------------------------------------------
`default_nettype none

module icmpp_csum (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire icmpp_pkg::csum_ctl_type           ctl,
   input  wire logic [7:0]                        data_byte,
   output logic [icmpp_pkg::WORD_BITS-1:0]        check_calc
);

   logic [icmpp_pkg::WORD_BITS-1:0] sum_ff;
   logic [icmpp_pkg::WORD_BITS-1:0] sum_in;
   logic [7:0]                      high_ff;
   logic [7:0]                      high_in;
   logic [icmpp_pkg::WORD_BITS-1:0] word;
   logic [icmpp_pkg::WORD_BITS-1:0] sum_step;

   // End-around carry on every add keeps the sum folded at all times.
   always_comb begin
      word     = ctl.pad_last ? {data_byte, 8'h00} : {high_ff, data_byte};
      sum_step = (ctl.add_pair || ctl.pad_last) ? icmpp_pkg::oc_add(sum_ff, word) : sum_ff;
      sum_in   = sum_ff;
      high_in  = high_ff;
      if (ctl.advance) begin
         if (ctl.restart) begin
            sum_in  = '0;
            high_in = '0;
         end else begin
            sum_in = sum_step;
            if (ctl.load_high) begin
               high_in = data_byte;
            end
         end
      end
   end

   assign check_calc = ~sum_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         high_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         high_ff <= high_in;
      end
   end

endmodule

`default_nettype wire
